@@ hdl/ssrp_pkg.sv @@
package ssrp_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int SEG_BITS_DEF   = 24;

    localparam int TGT_BITS     = 30;
    localparam int DONE_BITS    = 16;
    localparam int POS_BITS     = 32;
    localparam int ERR_BITS     = 16;
    localparam int MINC_BITS    = 15;
    localparam int ACT_BITS     = 2;
    localparam int CLK_BITS     = 3;
    localparam int CORR_SHIFT   = 5;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [MINC_BITS-1:0] MINC_RESET = 15'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_DIR    = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_CORRECTION = 1'b1;

    localparam logic [CLK_BITS-1:0] CLK_OFF  = 3'd0;
    localparam logic [CLK_BITS-1:0] CLK_DIV1 = 3'd1;
    localparam logic [CLK_BITS-1:0] CLK_DIV2 = 3'd2;
    localparam logic [CLK_BITS-1:0] CLK_DIV4 = 3'd3;
    localparam logic [CLK_BITS-1:0] CLK_DIV8 = 3'd4;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_SET_POS = 2'd0,
        ACT_PREP    = 2'd1,
        ACT_LOAD    = 2'd2,
        ACT_IGNORE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_POS,
        ST_PREP_DIFF,
        ST_PREP_LIMIT,
        ST_PREP_APPLY,
        ST_PREP_MAG,
        ST_PREP_DIV,
        ST_PREP_CLOCK,
        ST_LOAD_ENC,
        ST_LOAD_ERR,
        ST_LOAD_SUB,
        ST_LOAD_FIN,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CAPTURE,
        OP_SET_POS,
        OP_PREP_DIFF,
        OP_PREP_LIMIT,
        OP_PREP_APPLY,
        OP_PREP_MAG,
        OP_DIV_STEP,
        OP_PREP_CLOCK,
        OP_LOAD_ENC,
        OP_LOAD_ERR,
        OP_LOAD_SUB,
        OP_LOAD_FIN,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    div_last;
        logic    out_free;
    } dp_stat_t;

endpackage

@@ hdl/ssrp_ctrl.sv @@
module ssrp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ssrp_pkg::dp_stat_t stat,
    output ssrp_pkg::dp_cmd_t  cmd
);

    ssrp_pkg::state_t state_reg;
    ssrp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ssrp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssrp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ssrp_pkg::ST_DECODE;
                end
            end
            ssrp_pkg::ST_DECODE: begin
                unique case (stat.action)
                    ssrp_pkg::ACT_SET_POS: state_next = ssrp_pkg::ST_SET_POS;
                    ssrp_pkg::ACT_PREP:    state_next = ssrp_pkg::ST_PREP_DIFF;
                    ssrp_pkg::ACT_LOAD:    state_next = ssrp_pkg::ST_LOAD_ENC;
                    ssrp_pkg::ACT_IGNORE:  state_next = ssrp_pkg::ST_EMIT;
                endcase
            end
            ssrp_pkg::ST_SET_POS:    state_next = ssrp_pkg::ST_EMIT;
            ssrp_pkg::ST_PREP_DIFF:  state_next = ssrp_pkg::ST_PREP_LIMIT;
            ssrp_pkg::ST_PREP_LIMIT: state_next = ssrp_pkg::ST_PREP_APPLY;
            ssrp_pkg::ST_PREP_APPLY: state_next = ssrp_pkg::ST_PREP_MAG;
            ssrp_pkg::ST_PREP_MAG:   state_next = ssrp_pkg::ST_PREP_DIV;
            ssrp_pkg::ST_PREP_DIV: begin
                if (stat.div_last) begin
                    state_next = ssrp_pkg::ST_PREP_CLOCK;
                end
            end
            ssrp_pkg::ST_PREP_CLOCK: state_next = ssrp_pkg::ST_EMIT;
            ssrp_pkg::ST_LOAD_ENC:   state_next = ssrp_pkg::ST_LOAD_ERR;
            ssrp_pkg::ST_LOAD_ERR:   state_next = ssrp_pkg::ST_LOAD_SUB;
            ssrp_pkg::ST_LOAD_SUB:   state_next = ssrp_pkg::ST_LOAD_FIN;
            ssrp_pkg::ST_LOAD_FIN:   state_next = ssrp_pkg::ST_EMIT;
            ssrp_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ssrp_pkg::ST_IDLE;
                end
            end
            default: state_next = ssrp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.op   = ssrp_pkg::OP_IDLE;
        unique case (state_reg)
            ssrp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = ssrp_pkg::OP_CAPTURE;
                end
            end
            ssrp_pkg::ST_DECODE:     cmd.op = ssrp_pkg::OP_IDLE;
            ssrp_pkg::ST_SET_POS:    cmd.op = ssrp_pkg::OP_SET_POS;
            ssrp_pkg::ST_PREP_DIFF:  cmd.op = ssrp_pkg::OP_PREP_DIFF;
            ssrp_pkg::ST_PREP_LIMIT: cmd.op = ssrp_pkg::OP_PREP_LIMIT;
            ssrp_pkg::ST_PREP_APPLY: cmd.op = ssrp_pkg::OP_PREP_APPLY;
            ssrp_pkg::ST_PREP_MAG:   cmd.op = ssrp_pkg::OP_PREP_MAG;
            ssrp_pkg::ST_PREP_DIV:   cmd.op = ssrp_pkg::OP_DIV_STEP;
            ssrp_pkg::ST_PREP_CLOCK: cmd.op = ssrp_pkg::OP_PREP_CLOCK;
            ssrp_pkg::ST_LOAD_ENC:   cmd.op = ssrp_pkg::OP_LOAD_ENC;
            ssrp_pkg::ST_LOAD_ERR:   cmd.op = ssrp_pkg::OP_LOAD_ERR;
            ssrp_pkg::ST_LOAD_SUB:   cmd.op = ssrp_pkg::OP_LOAD_SUB;
            ssrp_pkg::ST_LOAD_FIN:   cmd.op = ssrp_pkg::OP_LOAD_FIN;
            ssrp_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.op = ssrp_pkg::OP_EMIT;
                end
            end
            default: cmd.op = ssrp_pkg::OP_IDLE;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ssrp_pkg::ST_DECODE))
        else $error("accepted transaction did not start decoding");

    a_div_runs_to_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssrp_pkg::ST_PREP_DIV && !stat.div_last)
        |=> (state_reg == ssrp_pkg::ST_PREP_DIV))
        else $error("divider left before its last step");

endmodule

@@ hdl/ssrp_dpath.sv @@
module ssrp_dpath #(
    parameter int TIMER_BITS = ssrp_pkg::TIMER_BITS_DEF,
    parameter int SEG_BITS   = ssrp_pkg::SEG_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ssrp_pkg::dp_cmd_t                    cmd,
    output ssrp_pkg::dp_stat_t                   stat,
    input  logic [ssrp_pkg::ACT_BITS-1:0]        in_action,
    input  logic [ssrp_pkg::TGT_BITS-1:0]        in_target,
    input  logic [SEG_BITS-1:0]                  in_seg,
    input  logic [ssrp_pkg::DONE_BITS-1:0]       in_done,
    input  logic [TIMER_BITS-1:0]                in_tnow,
    input  logic                                 cfg_write,
    input  logic [ssrp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ssrp_pkg::MINC_BITS-1:0]       cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 out_dir,
    output logic [ssrp_pkg::CLK_BITS-1:0]        out_clk,
    output logic [TIMER_BITS-1:0]                out_per,
    output logic [TIMER_BITS-1:0]                out_start,
    output logic [SEG_BITS-1:0]                  out_steps,
    output logic [ssrp_pkg::POS_BITS-1:0]        out_pos,
    output logic [ssrp_pkg::POS_BITS-1:0]        out_enc,
    output logic [ssrp_pkg::ERR_BITS-1:0]        out_err
);

    localparam int PW     = ssrp_pkg::POS_BITS;
    localparam int EB     = ssrp_pkg::ERR_BITS;
    localparam int CB     = ssrp_pkg::CLK_BITS;
    localparam int DW     = PW + 1;
    localparam int EW     = EB + 1;
    localparam int LIM_W  = DW - ssrp_pkg::CORR_SHIFT + 1;
    localparam int CW     = TIMER_BITS + 4;
    localparam int TCW    = (SEG_BITS + 1 > TIMER_BITS + 4) ? SEG_BITS + 1 : TIMER_BITS + 4;
    localparam int DCNT_W = $clog2(SEG_BITS);
    localparam int TGT_EXT = PW - ssrp_pkg::TGT_BITS - 1;

    localparam logic [TCW-1:0] ONE_T  = TCW'(1);
    localparam logic [TCW-1:0] LIM_D1 = (ONE_T << TIMER_BITS) - ONE_T;
    localparam logic [TCW-1:0] LIM_D2 = (ONE_T << (TIMER_BITS + 1)) - ONE_T;
    localparam logic [TCW-1:0] LIM_D4 = (ONE_T << (TIMER_BITS + 2)) - ONE_T;
    localparam logic [TCW-1:0] LIM_D8 = (ONE_T << (TIMER_BITS + 3)) - ONE_T;

    // configuration
    logic                             rev_reg, rev_next;
    logic [ssrp_pkg::MINC_BITS-1:0]   minc_reg, minc_next;

    // planner state
    logic [PW-1:0]         plan_reg, plan_next;
    logic [PW-1:0]         cmd_pos_reg, cmd_pos_next;
    logic [PW-1:0]         act_pos_reg, act_pos_next;
    logic [EB-1:0]         err_reg, err_next;
    logic                  next_neg_reg, next_neg_next;
    logic                  prev_neg_reg, prev_neg_next;
    logic [CB-1:0]         next_clk_reg, next_clk_next;
    logic [CB-1:0]         prev_clk_reg, prev_clk_next;
    logic [TIMER_BITS-1:0] next_per_reg, next_per_next;
    logic [SEG_BITS-1:0]   next_steps_reg, next_steps_next;
    logic                  m_valid_reg, m_valid_next;

    // captured transaction and working registers
    ssrp_pkg::action_t                action_reg, action_next;
    logic [PW-1:0]                    tgt_reg, tgt_next;
    logic [SEG_BITS-1:0]              seg_reg, seg_next;
    logic [ssrp_pkg::DONE_BITS-1:0]   done_reg, done_next;
    logic [TIMER_BITS-1:0]            tnow_reg, tnow_next;
    logic [DW-1:0]                    delta_reg, delta_next;
    logic [EW-1:0]                    emag_reg, emag_next;
    logic [LIM_W-1:0]                 lim_reg, lim_next;
    logic                             corr_en_reg, corr_en_next;
    logic [SEG_BITS:0]                rem_reg, rem_next;
    logic [SEG_BITS-1:0]              quo_reg, quo_next;
    logic [DCNT_W-1:0]                dcnt_reg, dcnt_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic                             res_dir_reg, res_dir_next;
    logic [CB-1:0]                    res_clk_reg, res_clk_next;
    logic [TIMER_BITS-1:0]            res_per_reg, res_per_next;
    logic [TIMER_BITS-1:0]            res_start_reg, res_start_next;
    logic [SEG_BITS-1:0]              res_steps_reg, res_steps_next;
    logic                             o_dir_reg, o_dir_next;
    logic [CB-1:0]                    o_clk_reg, o_clk_next;
    logic [TIMER_BITS-1:0]            o_per_reg, o_per_next;
    logic [TIMER_BITS-1:0]            o_start_reg, o_start_next;
    logic [SEG_BITS-1:0]              o_steps_reg, o_steps_next;
    logic [PW-1:0]                    o_pos_reg, o_pos_next;
    logic [PW-1:0]                    o_enc_reg, o_enc_next;
    logic [EB-1:0]                    o_err_reg, o_err_next;

    // combinational helpers
    logic                  err_neg;
    logic [EW-1:0]         err_ext;
    logic [EW-1:0]         emag_calc;
    logic [DW-1:0]         delta_calc;
    logic [DW-1:0]         delta_abs;
    logic [LIM_W-1:0]      lim_calc;
    logic [EW-1:0]         corr_mag;
    logic [DW-1:0]         corr_ext;
    logic [EW-1:0]         err_adj;
    logic [SEG_BITS-1:0]   mag_sat;
    logic [SEG_BITS:0]     rem_shift;
    logic [SEG_BITS:0]     divisor;
    logic                  rem_ge;
    logic [TCW-1:0]        ticks;
    logic [CB-1:0]         clk_raw;
    logic [1:0]            clk_sh;
    logic [TCW-1:0]        per_full;
    logic [TIMER_BITS-1:0] per_raw;
    logic [CB-1:0]         clk_calc;
    logic [TIMER_BITS-1:0] per_fin;
    logic                  prev_on;
    logic [CB-1:0]         sh_up;
    logic [CB-1:0]         sh_dn;
    logic [CW-1:0]         tnow_ext;
    logic [CW-1:0]         count_sh;
    logic [CW-1:0]         per_ext;
    logic [CW-1:0]         count_sub;
    logic [TIMER_BITS-1:0] start_calc;
    logic [PW-1:0]         done_ext;
    logic [PW-1:0]         act_calc;
    logic [PW-1:0]         err_wide;

    assign err_neg    = err_reg[EB-1];
    assign err_ext    = {err_reg[EB-1], err_reg};
    assign emag_calc  = err_neg ? (EW'(0) - err_ext) : err_ext;
    assign delta_calc = {tgt_reg[PW-1], tgt_reg} - {plan_reg[PW-1], plan_reg};
    assign delta_abs  = delta_reg[DW-1] ? (DW'(0) - delta_reg) : delta_reg;
    assign lim_calc   = LIM_W'(delta_abs >> ssrp_pkg::CORR_SHIFT) + LIM_W'(1);
    assign corr_mag   = ({{(LIM_W-EW){1'b0}}, emag_reg} < lim_reg) ? emag_reg
                                                                 : lim_reg[EW-1:0];
    assign corr_ext   = {{(DW-EW){1'b0}}, corr_mag};
    assign err_adj    = err_neg ? (err_ext + corr_mag) : (err_ext - corr_mag);
    assign mag_sat    = (delta_abs[DW-1:SEG_BITS] != '0) ? {SEG_BITS{1'b1}}
                                                         : delta_abs[SEG_BITS-1:0];

    // restoring divider, one quotient bit a cycle
    assign rem_shift = {rem_reg[SEG_BITS-1:0], quo_reg[SEG_BITS-1]};
    assign divisor   = {1'b0, next_steps_reg};
    assign rem_ge    = (rem_shift >= divisor);

    assign ticks = TCW'(quo_reg) + ONE_T;

    always_comb begin
        priority if (ticks < LIM_D1) begin
            clk_raw = ssrp_pkg::CLK_DIV1;
            clk_sh  = 2'd0;
        end else if (ticks < LIM_D2) begin
            clk_raw = ssrp_pkg::CLK_DIV2;
            clk_sh  = 2'd1;
        end else if (ticks < LIM_D4) begin
            clk_raw = ssrp_pkg::CLK_DIV4;
            clk_sh  = 2'd2;
        end else if (ticks < LIM_D8) begin
            clk_raw = ssrp_pkg::CLK_DIV8;
            clk_sh  = 2'd3;
        end else begin
            clk_raw = ssrp_pkg::CLK_OFF;
            clk_sh  = 2'd0;
        end
    end

    assign per_full = (ticks >> clk_sh) + ONE_T;
    assign per_raw  = per_full[TIMER_BITS-1:0];
    assign clk_calc = (next_steps_reg == '0 || clk_raw == ssrp_pkg::CLK_OFF || per_raw == '0)
                      ? ssrp_pkg::CLK_OFF : clk_raw;
    assign per_fin  = (clk_calc == ssrp_pkg::CLK_OFF) ? '0 : per_raw;

    // load path: rescale the live count to the new prescaler
    assign prev_on    = (prev_clk_reg != ssrp_pkg::CLK_OFF);
    assign sh_up      = prev_clk_reg - next_clk_reg;
    assign sh_dn      = next_clk_reg - prev_clk_reg;
    assign tnow_ext   = {4'b0, tnow_reg};
    assign count_sh   = (prev_clk_reg >= next_clk_reg) ? (tnow_ext << sh_up)
                                                       : (tnow_ext >> sh_dn);
    assign per_ext    = {4'b0, next_per_reg};
    assign count_sub  = (per_ext <= count_reg) ? (count_reg - per_ext) : count_reg;
    assign start_calc = (!prev_on || per_ext <= count_reg) ? (next_per_reg >> 1)
                                                           : count_reg[TIMER_BITS-1:0];
    assign done_ext   = {{(PW-ssrp_pkg::DONE_BITS){1'b0}}, done_reg};
    assign act_calc   = prev_neg_reg ? (act_pos_reg - done_ext) : (act_pos_reg + done_ext);
    assign err_wide   = cmd_pos_reg - act_pos_reg;

    always_comb begin
        rev_next        = rev_reg;
        minc_next       = minc_reg;
        plan_next       = plan_reg;
        cmd_pos_next    = cmd_pos_reg;
        act_pos_next    = act_pos_reg;
        err_next        = err_reg;
        next_neg_next   = next_neg_reg;
        prev_neg_next   = prev_neg_reg;
        next_clk_next   = next_clk_reg;
        prev_clk_next   = prev_clk_reg;
        next_per_next   = next_per_reg;
        next_steps_next = next_steps_reg;
        m_valid_next    = m_valid_reg;
        action_next     = action_reg;
        tgt_next        = tgt_reg;
        seg_next        = seg_reg;
        done_next       = done_reg;
        tnow_next       = tnow_reg;
        delta_next      = delta_reg;
        emag_next       = emag_reg;
        lim_next        = lim_reg;
        corr_en_next    = corr_en_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dcnt_next       = dcnt_reg;
        count_next      = count_reg;
        res_dir_next    = res_dir_reg;
        res_clk_next    = res_clk_reg;
        res_per_next    = res_per_reg;
        res_start_next  = res_start_reg;
        res_steps_next  = res_steps_reg;
        o_dir_next      = o_dir_reg;
        o_clk_next      = o_clk_reg;
        o_per_next      = o_per_reg;
        o_start_next    = o_start_reg;
        o_steps_next    = o_steps_reg;
        o_pos_next      = o_pos_reg;
        o_enc_next      = o_enc_reg;
        o_err_next      = o_err_reg;

        if (cfg_write) begin
            unique case (cfg_index)
                ssrp_pkg::CFG_REVERSE_DIR:    rev_next  = cfg_data[0];
                ssrp_pkg::CFG_MIN_CORRECTION: minc_next = cfg_data;
            endcase
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (cmd.op)
            ssrp_pkg::OP_IDLE: begin
            end
            ssrp_pkg::OP_CAPTURE: begin
                action_next    = ssrp_pkg::action_t'(in_action);
                tgt_next       = {{TGT_EXT{in_target[ssrp_pkg::TGT_BITS-1]}}, in_target, 1'b0};
                seg_next       = in_seg;
                done_next      = in_done;
                tnow_next      = in_tnow;
                res_dir_next   = 1'b0;
                res_clk_next   = ssrp_pkg::CLK_OFF;
                res_per_next   = '0;
                res_start_next = '0;
                res_steps_next = '0;
            end
            ssrp_pkg::OP_SET_POS: begin
                plan_next    = tgt_reg;
                cmd_pos_next = tgt_reg;
                act_pos_next = tgt_reg;
                err_next     = '0;
            end
            ssrp_pkg::OP_PREP_DIFF: begin
                delta_next = delta_calc;
                emag_next  = emag_calc;
                plan_next  = tgt_reg;
            end
            ssrp_pkg::OP_PREP_LIMIT: begin
                lim_next     = lim_calc;
                corr_en_next = ({2'b0, minc_reg} <= emag_reg);
            end
            ssrp_pkg::OP_PREP_APPLY: begin
                if (corr_en_reg) begin
                    delta_next = err_neg ? (delta_reg - corr_ext) : (delta_reg + corr_ext);
                    err_next   = err_adj[EB-1:0];
                end
            end
            ssrp_pkg::OP_PREP_MAG: begin
                next_neg_next   = delta_reg[DW-1];
                next_steps_next = mag_sat;
                rem_next        = '0;
                quo_next        = seg_reg;
                dcnt_next       = '0;
            end
            ssrp_pkg::OP_DIV_STEP: begin
                quo_next  = {quo_reg[SEG_BITS-2:0], rem_ge};
                rem_next  = rem_ge ? (rem_shift - divisor) : rem_shift;
                dcnt_next = dcnt_reg + DCNT_W'(1);
            end
            ssrp_pkg::OP_PREP_CLOCK: begin
                next_clk_next  = clk_calc;
                next_per_next  = per_fin;
                res_dir_next   = next_neg_reg ^ rev_reg;
                res_clk_next   = clk_calc;
                res_per_next   = per_fin;
                res_steps_next = next_steps_reg;
            end
            ssrp_pkg::OP_LOAD_ENC: begin
                if (prev_on) begin
                    act_pos_next = act_calc;
                end
                count_next = count_sh;
            end
            ssrp_pkg::OP_LOAD_ERR: begin
                if (prev_on) begin
                    err_next = err_wide[EB-1:0];
                end
                count_next = count_sub;
            end
            ssrp_pkg::OP_LOAD_SUB: begin
                count_next = count_sub;
            end
            ssrp_pkg::OP_LOAD_FIN: begin
                res_start_next = start_calc;
                res_dir_next   = next_neg_reg ^ rev_reg;
                res_clk_next   = next_clk_reg;
                res_per_next   = (next_clk_reg != ssrp_pkg::CLK_OFF) ? next_per_reg : '0;
                res_steps_next = next_steps_reg;
                prev_clk_next  = next_clk_reg;
                next_clk_next  = ssrp_pkg::CLK_OFF;
                prev_neg_next  = next_neg_reg;
                cmd_pos_next   = plan_reg;
            end
            ssrp_pkg::OP_EMIT: begin
                o_dir_next   = res_dir_reg;
                o_clk_next   = res_clk_reg;
                o_per_next   = res_per_reg;
                o_start_next = res_start_reg;
                o_steps_next = res_steps_reg;
                o_pos_next   = plan_reg;
                o_enc_next   = act_pos_reg;
                o_err_next   = err_reg;
                m_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_reg        <= 1'b0;
            minc_reg       <= ssrp_pkg::MINC_RESET;
            plan_reg       <= '0;
            cmd_pos_reg    <= '0;
            act_pos_reg    <= '0;
            err_reg        <= '0;
            next_neg_reg   <= 1'b0;
            prev_neg_reg   <= 1'b0;
            next_clk_reg   <= ssrp_pkg::CLK_OFF;
            prev_clk_reg   <= ssrp_pkg::CLK_OFF;
            next_per_reg   <= '0;
            next_steps_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            rev_reg        <= rev_next;
            minc_reg       <= minc_next;
            plan_reg       <= plan_next;
            cmd_pos_reg    <= cmd_pos_next;
            act_pos_reg    <= act_pos_next;
            err_reg        <= err_next;
            next_neg_reg   <= next_neg_next;
            prev_neg_reg   <= prev_neg_next;
            next_clk_reg   <= next_clk_next;
            prev_clk_reg   <= prev_clk_next;
            next_per_reg   <= next_per_next;
            next_steps_reg <= next_steps_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg    <= action_next;
        tgt_reg       <= tgt_next;
        seg_reg       <= seg_next;
        done_reg      <= done_next;
        tnow_reg      <= tnow_next;
        delta_reg     <= delta_next;
        emag_reg      <= emag_next;
        lim_reg       <= lim_next;
        corr_en_reg   <= corr_en_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dcnt_reg      <= dcnt_next;
        count_reg     <= count_next;
        res_dir_reg   <= res_dir_next;
        res_clk_reg   <= res_clk_next;
        res_per_reg   <= res_per_next;
        res_start_reg <= res_start_next;
        res_steps_reg <= res_steps_next;
        o_dir_reg     <= o_dir_next;
        o_clk_reg     <= o_clk_next;
        o_per_reg     <= o_per_next;
        o_start_reg   <= o_start_next;
        o_steps_reg   <= o_steps_next;
        o_pos_reg     <= o_pos_next;
        o_enc_reg     <= o_enc_next;
        o_err_reg     <= o_err_next;
    end

    assign stat = '{action:   action_reg,
                    div_last: (dcnt_reg == DCNT_W'(SEG_BITS - 1)),
                    out_free: (!m_valid_reg || m_ready)};

    assign m_valid   = m_valid_reg;
    assign out_dir   = o_dir_reg;
    assign out_clk   = o_clk_reg;
    assign out_per   = o_per_reg;
    assign out_start = o_start_reg;
    assign out_steps = o_steps_reg;
    assign out_pos   = o_pos_reg;
    assign out_enc   = o_enc_reg;
    assign out_err   = o_err_reg;

    a_period_matches_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((o_clk_reg == ssrp_pkg::CLK_OFF) == (o_per_reg == '0)))
        else $error("period and clock select disagree");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ssrp_pkg::OP_EMIT) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transaction completed");

    a_clock_codes_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_clk_reg <= ssrp_pkg::CLK_DIV8) && (prev_clk_reg <= ssrp_pkg::CLK_DIV8))
        else $error("prescaler code out of range");

endmodule

@@ hdl/stepper_segment_rate_planner.sv @@
// Step-rate planner for one stepper motor, in half steps. Each input transaction carries
// an action in s_tuser: set position, prep (plan a move toward a target over a segment of
// base clocks) or load (retire the previous move and issue the prepared timer settings);
// every transaction yields exactly one result transaction. Items are handled one at a time
// by a controller and a datapath. Prep runs a restoring divider that forms one quotient bit
// of segment clocks per half step each cycle. The result sits in an output register,
// so a new transaction is accepted while a finished result waits for m_tready; a further
// result waits in place until that one is taken. The configuration port is always ready;
// write it only while no transaction is in progress.
module stepper_segment_rate_planner #(
    parameter int TIMER_BITS = ssrp_pkg::TIMER_BITS_DEF,
    parameter int SEG_BITS   = ssrp_pkg::SEG_BITS_DEF,
    localparam int IN_W  = ssrp_pkg::TGT_BITS + SEG_BITS + ssrp_pkg::DONE_BITS + TIMER_BITS,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = 1 + ssrp_pkg::CLK_BITS + 2 * TIMER_BITS + SEG_BITS
                         + 2 * ssrp_pkg::POS_BITS + ssrp_pkg::ERR_BITS,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // target_steps, segment_cycles, done_half_steps, timer_now
    input  logic [IN_TW-1:0]                  s_tdata,
    // action
    input  logic [ssrp_pkg::ACT_BITS-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dir_ccw, clock_select, period_ticks, start_count, move_half_steps,
    // position_out, encoder_out, error_out
    output logic [OUT_TW-1:0]                 m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssrp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ssrp_pkg::MINC_BITS-1:0]    cfg_data
);

    localparam int SEG_LO  = ssrp_pkg::TGT_BITS;
    localparam int DONE_LO = SEG_LO + SEG_BITS;
    localparam int TNOW_LO = DONE_LO + ssrp_pkg::DONE_BITS;

    ssrp_pkg::dp_cmd_t  cmd;
    ssrp_pkg::dp_stat_t stat;

    logic                              out_dir;
    logic [ssrp_pkg::CLK_BITS-1:0]     out_clk;
    logic [TIMER_BITS-1:0]             out_per;
    logic [TIMER_BITS-1:0]             out_start;
    logic [SEG_BITS-1:0]               out_steps;
    logic [ssrp_pkg::POS_BITS-1:0]     out_pos;
    logic [ssrp_pkg::POS_BITS-1:0]     out_enc;
    logic [ssrp_pkg::ERR_BITS-1:0]     out_err;

    assign cfg_ready = 1'b1;

    ssrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssrp_dpath #(
        .TIMER_BITS (TIMER_BITS),
        .SEG_BITS   (SEG_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_action (s_tuser),
        .in_target (s_tdata[ssrp_pkg::TGT_BITS-1:0]),
        .in_seg    (s_tdata[DONE_LO-1:SEG_LO]),
        .in_done   (s_tdata[TNOW_LO-1:DONE_LO]),
        .in_tnow   (s_tdata[TNOW_LO+TIMER_BITS-1:TNOW_LO]),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .out_dir   (out_dir),
        .out_clk   (out_clk),
        .out_per   (out_per),
        .out_start (out_start),
        .out_steps (out_steps),
        .out_pos   (out_pos),
        .out_enc   (out_enc),
        .out_err   (out_err)
    );

    assign m_tdata = OUT_TW'({out_err, out_enc, out_pos, out_steps,
                              out_start, out_per, out_clk, out_dir});

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

import ssrp_pkg::*;

typedef struct packed {
    logic [15:0] timer;
    logic [15:0] done;
    logic [23:0] seg;
    logic [29:0] target;
} item_t;

typedef struct packed {
    logic [15:0] error;
    logic [31:0] encoder;
    logic [31:0] position;
    logic [23:0] steps;
    logic [15:0] start;
    logic [15:0] period;
    logic [2:0]  clock;
    logic        dir;
} plan_t;

class planner_scoreboard;
    logic [31:0] plan_hs;
    logic [31:0] cmd_hs;
    logic [31:0] enc_hs;
    logic [15:0] err_hs;
    bit          queued_neg;
    bit          live_neg;
    logic [2:0]  queued_clk;
    logic [2:0]  live_clk;
    logic [15:0] queued_period;
    logic [23:0] queued_steps;
    bit          reverse;
    logic [14:0] min_corr;
    plan_t       expected_plans[$];
    int          n_fail;

    function new();
        plan_hs = '0;
        cmd_hs = '0;
        enc_hs = '0;
        err_hs = '0;
        queued_neg = 0;
        live_neg = 0;
        queued_clk = CLK_OFF;
        live_clk = CLK_OFF;
        queued_period = '0;
        queued_steps = '0;
        reverse = 0;
        min_corr = MINC_RESET;
        n_fail = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [14:0] val);
        if (idx == CFG_REVERSE_DIR) begin
            reverse = val[0];
        end else begin
            min_corr = val;
        end
    endfunction

    function void plan_prep(logic [29:0] tgt, logic [23:0] seg);
        longint t, delta, e, emag, ad, lim, corr, mag, ticks;
        logic [2:0] clk;
        logic [15:0] per;
        int sh;
        t = longint'($signed(tgt)) * 2;
        delta = t - longint'($signed(plan_hs));
        e = longint'($signed(err_hs));
        emag = (e < 0) ? -e : e;
        plan_hs = t[31:0];
        // bounded correction of the accumulated error
        if (longint'(min_corr) <= emag) begin
            ad = (delta < 0) ? -delta : delta;
            lim = (ad >>> CORR_SHIFT) + 1;
            corr = (emag < lim) ? emag : lim;
            if (e < 0) begin
                corr = -corr;
            end
            delta = delta + corr;
            e = e - corr;
        end
        err_hs = e[15:0];
        queued_neg = (delta < 0);
        mag = (delta < 0) ? -delta : delta;
        if (mag > 64'hffffff) begin
            mag = 64'hffffff;
        end
        clk = CLK_OFF;
        per = '0;
        sh = 0;
        if (mag != 0) begin
            ticks = longint'(seg) / mag + 1;
            if (ticks < 64'hffff) begin
                clk = CLK_DIV1;
                sh = 0;
            end else if (ticks < 64'h1ffff) begin
                clk = CLK_DIV2;
                sh = 1;
            end else if (ticks < 64'h3ffff) begin
                clk = CLK_DIV4;
                sh = 2;
            end else if (ticks < 64'h7ffff) begin
                clk = CLK_DIV8;
                sh = 3;
            end
            if (clk != CLK_OFF) begin
                per = 16'((ticks >> sh) + 1);
                if (per == 0) begin
                    clk = CLK_OFF;
                end
            end
        end
        queued_clk = clk;
        queued_period = per;
        queued_steps = mag[23:0];
    endfunction

    function logic [15:0] plan_load(logic [15:0] done, logic [15:0] tnow);
        longint cnt, per, h, enc;
        per = longint'(queued_period);
        if (live_clk != CLK_OFF) begin
            h = longint'(done);
            enc = longint'($signed(enc_hs)) + (live_neg ? -h : h);
            enc_hs = enc[31:0];
            err_hs = 16'(longint'($signed(cmd_hs)) - longint'($signed(enc_hs)));
            cnt = longint'(tnow);
            // rescale the running count to the new prescaler
            if (live_clk >= queued_clk) begin
                cnt = cnt << (live_clk - queued_clk);
            end else begin
                cnt = cnt >> (queued_clk - live_clk);
            end
            if (per <= cnt) begin
                cnt = cnt - per;
            end
            if (per <= cnt) begin
                cnt = cnt - per;
            end
            if (per <= cnt) begin
                cnt = per >> 1;
            end
        end else begin
            cnt = per >> 1;
        end
        live_clk = queued_clk;
        queued_clk = CLK_OFF;
        live_neg = queued_neg;
        cmd_hs = plan_hs;
        return cnt[15:0];
    endfunction

    function void note_item(action_t act, item_t it);
        plan_t p;
        p = '0;
        case (act)
            ACT_SET_POS: begin
                plan_hs = 32'(longint'($signed(it.target)) * 2);
                cmd_hs = plan_hs;
                enc_hs = plan_hs;
                err_hs = '0;
            end
            ACT_PREP: begin
                plan_prep(it.target, it.seg);
                p.dir = queued_neg ^ reverse;
                p.clock = queued_clk;
                p.period = (queued_clk != CLK_OFF) ? queued_period : 16'd0;
                p.steps = queued_steps;
            end
            ACT_LOAD: begin
                p.start = plan_load(it.done, it.timer);
                p.dir = live_neg ^ reverse;
                p.clock = live_clk;
                p.period = (live_clk != CLK_OFF) ? queued_period : 16'd0;
                p.steps = queued_steps;
            end
            default: begin
            end
        endcase
        p.position = plan_hs;
        p.encoder = enc_hs;
        p.error = err_hs;
        expected_plans.push_back(p);
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] got);
        if (exp !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp, got);
            n_fail++;
        end
    endfunction

    function void check_result(plan_t got);
        plan_t exp;
        if (expected_plans.size() == 0) begin
            $error("result transaction with none expected");
            n_fail++;
            return;
        end
        exp = expected_plans.pop_front();
        compare("dir_ccw", exp.dir, got.dir);
        compare("clock_select", exp.clock, got.clock);
        compare("period_ticks", exp.period, got.period);
        compare("start_count", exp.start, got.start);
        compare("move_half_steps", exp.steps, got.steps);
        compare("position_out", exp.position, got.position);
        compare("encoder_out", exp.encoder, got.encoder);
        compare("error_out", exp.error, got.error);
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [87:0]             s_tdata = '0;
    logic [ACT_BITS-1:0]     s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [143:0]            m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [MINC_BITS-1:0]    cfg_data = '0;

    planner_scoreboard sb = new();

    bit          quiet = 0;
    int          n_results = 0;
    int          hold_left = 0;
    int          rx_idle = 0;
    bit          long_hold_done = 0;
    int          stall_cycles = 0;
    logic [23:0] issued_steps = '0;

    stepper_segment_rate_planner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: checking, random back-pressure and one long hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(plan_t'(m_tdata[139:0]));
                n_results++;
            end
            if (!long_hold_done && n_results >= 60) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_idle > 0) begin
                rx_idle--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rx_idle = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic item_t rand_item();
        return 86'({$urandom, $urandom, $urandom});
    endfunction

    task automatic send_item(action_t act, item_t it);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {2'b00, it};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(act, it);
    endtask

    task automatic drive_set_pos(logic [29:0] tgt);
        item_t it;
        it = rand_item();
        it.target = tgt;
        send_item(ACT_SET_POS, it);
    endtask

    task automatic drive_prep(logic [29:0] tgt, logic [23:0] seg);
        item_t it;
        it = rand_item();
        it.target = tgt;
        it.seg = seg;
        send_item(ACT_PREP, it);
    endtask

    task automatic drive_load(logic [15:0] done, logic [15:0] tnow);
        item_t it;
        it = rand_item();
        it.done = done;
        it.timer = tnow;
        send_item(ACT_LOAD, it);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_plans.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(bit rev, logic [14:0] minc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_REVERSE_DIR;
        cfg_data <= {14'd0, rev};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(CFG_REVERSE_DIR, {14'd0, rev});
        cfg_index <= CFG_MIN_CORRECTION;
        cfg_data <= minc;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(CFG_MIN_CORRECTION, minc);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int n);
        int          sent;
        int unsigned r;
        longint      cur;
        longint      stepv;
        item_t       it;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            it = rand_item();
            if (r < 4) begin
                send_item(ACT_IGNORE, it);
            end else if (r < 10) begin
                if (r < 7) begin
                    it.target = 30'(longint'($urandom_range(0, 2000)) - 1000);
                end
                send_item(ACT_SET_POS, it);
            end else if (r < 16) begin
                send_item(ACT_PREP, it);
            end else if (r < 22) begin
                send_item(ACT_LOAD, it);
            end else begin
                // a prep followed by a load that retires roughly the issued move
                cur = longint'($signed(sb.plan_hs)) >>> 1;
                case ($urandom_range(0, 3))
                    0: stepv = longint'($urandom_range(0, 8)) - 4;
                    1: stepv = longint'($urandom_range(0, 600)) - 300;
                    2: stepv = longint'($urandom_range(0, 40000)) - 20000;
                    default: stepv = longint'($signed(it.target)) - cur;
                endcase
                it.target = 30'(cur + stepv);
                case ($urandom_range(0, 3))
                    0: it.seg = 24'($urandom_range(0, 2000));
                    1: it.seg = 24'($urandom_range(2000, 200000));
                    2: it.seg = 24'($urandom_range(200000, 4000000));
                    default: begin
                    end
                endcase
                send_item(ACT_PREP, it);
                it = rand_item();
                if ($urandom_range(0, 4) != 0) begin
                    it.done = 16'(longint'(issued_steps) + longint'($urandom_range(0, 6)) - 3);
                end
                send_item(ACT_LOAD, it);
                issued_steps = sb.queued_steps;
                sent++;
            end
            sent++;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(ACT_IGNORE, rand_item());
        drive_load(16'hffff, 16'hffff);
        drive_set_pos(30'h1fffffff);
        drive_prep(30'h20000000, 24'hffffff);
        drive_prep(30'h20000000, 24'h000000);
        drive_set_pos(30'h20000000);
        drive_set_pos(30'd0);
        drive_prep(30'd1, 24'd262138);
        drive_load(16'd100, 16'd500);
        drive_prep(30'd2, 24'hffffff);
        drive_set_pos(30'd0);
        drive_prep(30'd100, 24'd1000);
        drive_load(16'd0, 16'hffff);
        drive_prep(30'd50, 24'hffffff);
        drive_load(16'd150, 16'hffff);
        drive_prep(30'd0, 24'd300);
        drive_load(16'd100, 16'd40000);
        drive_load(16'd7, 16'd9);
        drive_set_pos(30'd0);
        drive_prep(30'd100, 24'd5000);
        drive_load(16'd0, 16'd0);
        drive_prep(30'd200, 24'd5000);
        drive_load(16'd32968, 16'd1234);
        drive_prep(30'd150, 24'd5000);
        drive_load(16'hffff, 16'hffff);

        wait_drained();
        set_config(1'b1, 15'd0);
        random_items(130);

        wait_drained();
        set_config(1'b0, 15'h7fff);
        random_items(130);

        wait_drained();
        set_config(1'b1, 15'($urandom_range(1, 40)));
        quiet = 1;
        random_items(140);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
